/* rtl/core/gamepad_radial_deadzone_filter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of the deadzone filter.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_RADIAL_DEADZONE_FILTER_ASSERT_SVH
`define GAMEPAD_RADIAL_DEADZONE_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GRDZ_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deadzone filter check failed");

// Next-cycle implication, checked outside reset.
`define GRDZ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deadzone filter check failed");

`endif

/* rtl/core/grdz_pkg.sv */
// ----------------------------------------------------------------------------
// grdz_pkg
// Widths, register codes and the per-step functions of the root and divide
// pipelines of the radial deadzone filter.
// ----------------------------------------------------------------------------
`default_nettype none

package grdz_pkg;

    // Internal axis magnitude and product widths.
    localparam int AXW        = 16;
    localparam int SQW        = 31;
    localparam int RADW       = 32;
    localparam int ROOTW      = 16;
    localparam int REMW       = 17;
    localparam int CFGW       = 15;
    localparam int TCFGW      = 8;
    localparam int QW         = 15;
    localparam int DIVW       = 31;
    localparam int NAX        = 4;
    localparam int NSTK       = 2;
    localparam int NTRG       = 2;
    localparam int NLANE      = NAX + NTRG;
    localparam int SQRT_STEPS = ROOTW;
    localparam int DIV_STEPS  = QW;
    // Input, square, sum, clamp, multiply, compare and output registers.
    localparam int LATENCY    = SQRT_STEPS + DIV_STEPS + 7;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_STICK_LIMIT   = 3'd0,
        REG_STICK_LIMIT_Y = 3'd1,
        REG_LEFT_DZ       = 3'd2,
        REG_RIGHT_DZ      = 3'd3,
        REG_RIGHT_DIV     = 3'd4,
        REG_TRIG_DZ       = 3'd5,
        REG_TRIG_FULL     = 3'd6
    } t_reg_idx;

    // One lane of the digit-by-digit square root.
    typedef struct packed {
        logic [RADW-1:0]  rad;
        logic [REMW-1:0]  rem;
        logic [ROOTW-1:0] root;
    } t_sq_st;

    // One lane of the restoring divider.
    typedef struct packed {
        logic [DIVW-1:0] rem;
        logic [DIVW-1:0] den;
        logic [QW-1:0]   quo;
    } t_dv_st;

    // Flags that travel beside the divider lanes.
    typedef struct packed {
        logic [15:0]     buttons;
        logic [NAX-1:0]  azero;
        logic [NAX-1:0]  sat;
        logic [NAX-1:0]  neg;
        logic [NTRG-1:0] tzero;
        logic [NTRG-1:0] tsat;
    } t_flags;

    // Resolve one root bit from the next two radicand bits.
    function automatic t_sq_st sqrt_step(input t_sq_st a);
        logic [REMW+1:0] r2;
        logic [REMW+1:0] tr;
        t_sq_st          o;
        r2 = {a.rem, a.rad[RADW-1 -: 2]};
        tr = {1'b0, a.root, 2'b01};
        o.rad = {a.rad[RADW-3:0], 2'b00};
        if (r2 >= tr) begin
            o.rem  = REMW'(r2 - tr);
            o.root = {a.root[ROOTW-2:0], 1'b1};
        end else begin
            o.rem  = r2[REMW-1:0];
            o.root = {a.root[ROOTW-2:0], 1'b0};
        end
        return o;
    endfunction

    // Resolve one quotient bit; the remainder stays below the divisor.
    function automatic t_dv_st div_step(input t_dv_st a);
        logic [DIVW:0] r2;
        t_dv_st        o;
        r2    = {a.rem, 1'b0};
        o.den = a.den;
        if (r2 >= {1'b0, a.den}) begin
            o.rem = DIVW'(r2 - {1'b0, a.den});
            o.quo = {a.quo[QW-2:0], 1'b1};
        end else begin
            o.rem = r2[DIVW-1:0];
            o.quo = {a.quo[QW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/gamepad_radial_deadzone_filter.sv */
// ----------------------------------------------------------------------------
// gamepad_radial_deadzone_filter
// Scaled radial deadzone for gamepad reports: sticks are rescaled to signed
// Q1.15 and triggers to unsigned Q0.15, buttons pass through.
// ----------------------------------------------------------------------------
// Usage:
// A report word is taken at a rising edge with start high and busy low.
// busy never rises, so one report can be taken in every cycle.
// Each report gives one result word, shown for a single cycle with o_valid
// high; the result is taken at the edge that ends that cycle. The receiver
// cannot stall the block.
// The pipeline is an input register, a square, a sum, a 16-stage root pipeline
// (one root bit a stage), clamp, multiply, compare, a 15-stage divider (one
// quotient bit a stage) and an output register; these stages set the latency.
// Configuration words use i_cfg_valid / o_cfg_ready; o_cfg_ready is always
// high. Registers should change only while no report is in flight.
// Synchronous reset (i_rst_n low) empties the pipeline and loads the
// register defaults; nothing is shown while reset is held.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_radial_deadzone_filter
    import grdz_pkg::*;
#(
    parameter int AXIS_BITS    = 16,
    parameter int TRIGGER_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [15:0]                    i_buttons_in,
    input  logic signed [AXIS_BITS-1:0]    i_left_x_in,
    input  logic signed [AXIS_BITS-1:0]    i_left_y_in,
    input  logic signed [AXIS_BITS-1:0]    i_right_x_in,
    input  logic signed [AXIS_BITS-1:0]    i_right_y_in,
    input  logic [TRIGGER_BITS-1:0]        i_left_trigger_in,
    input  logic [TRIGGER_BITS-1:0]        i_right_trigger_in,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [CFGW-1:0]                i_cfg_data,
    output logic                           o_valid,
    output logic [15:0]                    o_buttons_out,
    output logic signed [15:0]             o_left_x_out,
    output logic signed [15:0]             o_left_y_out,
    output logic signed [15:0]             o_right_x_out,
    output logic signed [15:0]             o_right_y_out,
    output logic [14:0]                    o_left_trigger_out,
    output logic [14:0]                    o_right_trigger_out
);

    // Word carried beside the root pipeline.
    typedef struct packed {
        logic [15:0]                        buttons;
        logic [NAX-1:0][AXW-1:0]            mag;
        logic [NAX-1:0]                     neg;
        logic [NTRG-1:0][TRIGGER_BITS-1:0]  trig;
    } t_sq_side;

    typedef struct packed {
        logic [15:0]                        buttons;
        logic [NAX-1:0][AXW-1:0]            ax;
        logic [NTRG-1:0][TRIGGER_BITS-1:0]  trig;
    } t_s1;

    typedef struct packed {
        logic [15:0]                        buttons;
        logic [NAX-1:0][AXW-1:0]            mag;
        logic [NAX-1:0]                     neg;
        logic [NAX-1:0][SQW-1:0]            sq;
        logic [NTRG-1:0][TRIGGER_BITS-1:0]  trig;
    } t_s2;

    typedef struct packed {
        logic [NSTK-1:0][RADW-1:0]          rad;
        t_sq_side                           side;
    } t_s3;

    typedef struct packed {
        logic [15:0]                        buttons;
        logic [NAX-1:0][AXW-1:0]            mag;
        logic [NAX-1:0]                     neg;
        logic [NSTK-1:0][CFGW-1:0]          num;
        logic [NSTK-1:0][CFGW-1:0]          den;
        logic [NSTK-1:0]                    szero;
        logic [NTRG-1:0]                    tzero;
        logic [NTRG-1:0]                    tsat;
        logic [NTRG-1:0][TCFGW-1:0]         tdiff;
        logic [TCFGW-1:0]                   tden;
    } t_e;

    typedef struct packed {
        logic [15:0]                        buttons;
        logic [NAX-1:0][DIVW-1:0]           p;
        logic [NAX-1:0][DIVW-1:0]           d;
        logic [NAX-1:0]                     azero;
        logic [NAX-1:0]                     neg;
        logic [NTRG-1:0]                    tzero;
        logic [NTRG-1:0]                    tsat;
        logic [NTRG-1:0][TCFGW-1:0]         tdiff;
        logic [TCFGW-1:0]                   tden;
    } t_f;

    typedef struct packed {
        logic [NLANE-1:0][DIVW-1:0]         rem;
        logic [NLANE-1:0][DIVW-1:0]         den;
        t_flags                             flags;
    } t_g;

    localparam int SIDE_W = $bits(t_sq_side);

    // Configuration registers.
    logic [CFGW-1:0]  r_stick_limit;
    logic [CFGW-1:0]  r_stick_limit_y;
    logic [CFGW-1:0]  r_left_dz;
    logic [CFGW-1:0]  r_right_dz;
    logic [CFGW-1:0]  r_right_div;
    logic [TCFGW-1:0] r_trig_dz;
    logic [TCFGW-1:0] r_trig_full;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_e_valid, r_f_valid, r_g_valid;
    logic r_h_valid;
    t_s1  r_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_e   r_e, n_e;
    t_f   r_f, n_f;
    t_g   r_g, n_g;

    logic                        sq_valid;
    logic [NSTK-1:0][ROOTW-1:0]  sq_root;
    logic [SIDE_W-1:0]           sq_side_bits;
    t_sq_side                    sq_side;

    logic                        dv_valid;
    logic [NLANE-1:0][QW-1:0]    dv_quo;
    t_flags                      dv_flags;

    logic [15:0]                 r_buttons;
    logic [NAX-1:0][15:0]        r_axis_out, n_axis_out;
    logic [NTRG-1:0][14:0]       r_trig_out, n_trig_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_limit   <= 15'd32767;
            r_stick_limit_y <= 15'd32767;
            r_left_dz       <= 15'd7849;
            r_right_dz      <= 15'd8689;
            r_right_div     <= 15'd32767;
            r_trig_dz       <= 8'd30;
            r_trig_full     <= 8'd255;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_STICK_LIMIT:   r_stick_limit   <= i_cfg_data;
                REG_STICK_LIMIT_Y: r_stick_limit_y <= i_cfg_data;
                REG_LEFT_DZ:       r_left_dz       <= i_cfg_data;
                REG_RIGHT_DZ:      r_right_dz      <= i_cfg_data;
                REG_RIGHT_DIV:     r_right_div     <= i_cfg_data;
                REG_TRIG_DZ:       r_trig_dz       <= i_cfg_data[TCFGW-1:0];
                REG_TRIG_FULL:     r_trig_full     <= i_cfg_data[TCFGW-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits of the stages outside the root and divide pipelines.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_e_valid  <= 1'b0;
            r_f_valid  <= 1'b0;
            r_g_valid  <= 1'b0;
            r_h_valid  <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_e_valid  <= sq_valid;
            r_f_valid  <= r_e_valid;
            r_g_valid  <= r_f_valid;
            r_h_valid  <= dv_valid;
        end
    end

    // Input register with axes sign-extended to the internal width.
    always_ff @(posedge i_clk) begin
        r_s1.buttons <= i_buttons_in;
        r_s1.ax[0]   <= AXW'(i_left_x_in);
        r_s1.ax[1]   <= AXW'(i_left_y_in);
        r_s1.ax[2]   <= AXW'(i_right_x_in);
        r_s1.ax[3]   <= AXW'(i_right_y_in);
        r_s1.trig[0] <= i_left_trigger_in;
        r_s1.trig[1] <= i_right_trigger_in;
    end

    // Magnitudes and their squares.
    always_comb begin
        n_s2.buttons = r_s1.buttons;
        n_s2.trig    = r_s1.trig;
        for (int i = 0; i < NAX; i++) begin
            n_s2.neg[i] = r_s1.ax[i][AXW-1];
            n_s2.mag[i] = r_s1.ax[i][AXW-1] ? (~r_s1.ax[i] + AXW'(1)) : r_s1.ax[i];
            n_s2.sq[i]  = SQW'(32'(n_s2.mag[i]) * 32'(n_s2.mag[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    // Sum of squares per stick.
    always_comb begin
        for (int s = 0; s < NSTK; s++) begin
            n_s3.rad[s] = RADW'(r_s2.sq[2*s]) + RADW'(r_s2.sq[2*s+1]);
        end
        n_s3.side.buttons = r_s2.buttons;
        n_s3.side.mag     = r_s2.mag;
        n_s3.side.neg     = r_s2.neg;
        n_s3.side.trig    = r_s2.trig;
    end

    always_ff @(posedge i_clk) begin
        r_s3 <= n_s3;
    end

    grdz_sqrt #(
        .LANES  (NSTK),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_rad   (r_s3.rad),
        .i_side  (r_s3.side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side_bits)
    );

    assign sq_side = t_sq_side'(sq_side_bits);

    // Deadzone test, magnitude clamp, and trigger offsets.
    always_comb begin
        logic [CFGW-1:0]         dz;
        logic [CFGW-1:0]         mc;
        logic [TRIGGER_BITS-1:0] tfull;
        n_e.buttons = sq_side.buttons;
        n_e.mag     = sq_side.mag;
        n_e.neg     = sq_side.neg;
        for (int s = 0; s < NSTK; s++) begin
            dz = (s == 0) ? r_left_dz : r_right_dz;
            mc = (sq_root[s] > ROOTW'(r_stick_limit)) ? r_stick_limit
                                                      : sq_root[s][CFGW-1:0];
            n_e.szero[s] = (dz >= r_stick_limit) || (sq_root[s] <= ROOTW'(dz));
            n_e.num[s]   = mc - dz;
            n_e.den[s]   = r_stick_limit - dz;
        end
        n_e.tden = r_trig_full - r_trig_dz;
        for (int t = 0; t < NTRG; t++) begin
            tfull        = sq_side.trig[t] - TRIGGER_BITS'(r_trig_dz);
            n_e.tzero[t] = (r_trig_full <= r_trig_dz) ||
                           (sq_side.trig[t] <= TRIGGER_BITS'(r_trig_dz));
            n_e.tsat[t]  = tfull >= TRIGGER_BITS'(n_e.tden);
            n_e.tdiff[t] = tfull[TCFGW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    // Numerator and denominator products per axis.
    always_comb begin
        logic [CFGW-1:0] dv;
        n_f.buttons = r_e.buttons;
        n_f.neg     = r_e.neg;
        n_f.tzero   = r_e.tzero;
        n_f.tsat    = r_e.tsat;
        n_f.tdiff   = r_e.tdiff;
        n_f.tden    = r_e.tden;
        for (int i = 0; i < NAX; i++) begin
            priority case (i)
                0:       dv = r_stick_limit;
                1:       dv = r_stick_limit_y;
                default: dv = r_right_div;
            endcase
            n_f.p[i]     = DIVW'(DIVW'(r_e.num[i/2]) * DIVW'(r_e.mag[i]));
            n_f.d[i]     = DIVW'(DIVW'(r_e.den[i/2]) * DIVW'(dv));
            n_f.azero[i] = r_e.szero[i/2] || (dv == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
    end

    // Saturation test; only fractions below one enter the divider.
    always_comb begin
        n_g.flags.buttons = r_f.buttons;
        n_g.flags.azero   = r_f.azero;
        n_g.flags.neg     = r_f.neg;
        n_g.flags.tzero   = r_f.tzero;
        n_g.flags.tsat    = r_f.tsat;
        for (int i = 0; i < NAX; i++) begin
            n_g.flags.sat[i] = r_f.p[i] >= r_f.d[i];
            n_g.rem[i] = (n_g.flags.sat[i] || r_f.azero[i]) ? '0 : r_f.p[i];
            n_g.den[i] = r_f.d[i];
        end
        for (int t = 0; t < NTRG; t++) begin
            n_g.rem[NAX+t] = (r_f.tsat[t] || r_f.tzero[t]) ? '0 : DIVW'(r_f.tdiff[t]);
            n_g.den[NAX+t] = DIVW'(r_f.tden);
        end
    end

    always_ff @(posedge i_clk) begin
        r_g <= n_g;
    end

    grdz_div #(
        .LANES (NLANE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_g_valid),
        .i_rem   (r_g.rem),
        .i_den   (r_g.den),
        .i_flags (r_g.flags),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_flags (dv_flags)
    );

    // Sign, saturation and zeroing of the results.
    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            priority if (dv_flags.azero[i]) begin
                n_axis_out[i] = '0;
            end else if (dv_flags.sat[i]) begin
                n_axis_out[i] = dv_flags.neg[i] ? 16'h8000 : 16'h7FFF;
            end else begin
                n_axis_out[i] = dv_flags.neg[i] ? (16'd0 - {1'b0, dv_quo[i]})
                                                : {1'b0, dv_quo[i]};
            end
        end
        for (int t = 0; t < NTRG; t++) begin
            priority if (dv_flags.tzero[t]) begin
                n_trig_out[t] = '0;
            end else if (dv_flags.tsat[t]) begin
                n_trig_out[t] = 15'h7FFF;
            end else begin
                n_trig_out[t] = dv_quo[NAX+t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buttons  <= dv_flags.buttons;
        r_axis_out <= n_axis_out;
        r_trig_out <= n_trig_out;
    end

    assign o_valid             = r_h_valid;
    assign o_buttons_out       = r_buttons;
    assign o_left_x_out        = r_axis_out[0];
    assign o_left_y_out        = r_axis_out[1];
    assign o_right_x_out       = r_axis_out[2];
    assign o_right_y_out       = r_axis_out[3];
    assign o_left_trigger_out  = r_trig_out[0];
    assign o_right_trigger_out = r_trig_out[1];

endmodule

`default_nettype wire

/* rtl/core/grdz_sqrt.sv */
// ----------------------------------------------------------------------------
// grdz_sqrt
// Pipelined integer square root, one root bit per register stage, with a
// sideband word that travels in step with the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module grdz_sqrt
    import grdz_pkg::*;
#(
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [LANES-1:0][RADW-1:0]  i_rad,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][ROOTW-1:0] o_root,
    output logic [SIDE_W-1:0]           o_side
);

    logic [SQRT_STEPS-1:0] r_valid;
    t_sq_st                r_st   [SQRT_STEPS][LANES];
    logic [SIDE_W-1:0]     r_side [SQRT_STEPS];
    t_sq_st                seed   [LANES];

    // Each lane starts with an empty root and remainder.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            seed[l] = '{rad: i_rad[l], rem: '0, root: '0};
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[SQRT_STEPS-2:0], i_valid};
        end
    end

    // One root bit per stage.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_st[0][l] <= sqrt_step(seed[l]);
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_st[k][l] <= sqrt_step(r_st[k-1][l]);
            end
        end
        r_side[0] <= i_side;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_root[l] = r_st[SQRT_STEPS-1][l].root;
        end
    end

    assign o_valid = r_valid[SQRT_STEPS-1];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule

`default_nettype wire

/* rtl/core/grdz_div.sv */
// ----------------------------------------------------------------------------
// grdz_div
// Pipelined restoring divider for fractions below one: one quotient bit per
// register stage, flags carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module grdz_div
    import grdz_pkg::*;
#(
    parameter int LANES = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [LANES-1:0][DIVW-1:0] i_rem,
    input  logic [LANES-1:0][DIVW-1:0] i_den,
    input  t_flags                     i_flags,
    output logic                       o_valid,
    output logic [LANES-1:0][QW-1:0]   o_quo,
    output t_flags                     o_flags
);

    logic [DIV_STEPS-1:0] r_valid;
    t_dv_st               r_st    [DIV_STEPS][LANES];
    t_flags               r_flags [DIV_STEPS];
    t_dv_st               seed    [LANES];

    // The numerator enters as the starting remainder.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            seed[l] = '{rem: i_rem[l], den: i_den[l], quo: '0};
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[DIV_STEPS-2:0], i_valid};
        end
    end

    // One quotient bit per stage.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_st[0][l] <= div_step(seed[l]);
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_st[k][l] <= div_step(r_st[k-1][l]);
            end
        end
        r_flags[0] <= i_flags;
        for (int k = 1; k < DIV_STEPS; k++) begin
            r_flags[k] <= r_flags[k-1];
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_st[DIV_STEPS-1][l].quo;
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_flags = r_flags[DIV_STEPS-1];

endmodule

`default_nettype wire

/* rtl/core/grdz_checker.sv */
// ----------------------------------------------------------------------------
// grdz_checker
// Port-level checks of the deadzone filter: fixed latency, button pass-through and left x sign.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gamepad_radial_deadzone_filter_assert.svh"

module grdz_checker
    import grdz_pkg::*;
#(
    parameter int AXIS_BITS = 16
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_valid,
    input wire logic [15:0]                 i_buttons_in,
    input wire logic [15:0]                 o_buttons_out,
    input wire logic signed [AXIS_BITS-1:0] i_left_x_in,
    input wire logic signed [15:0]          o_left_x_out
);

    localparam int CNTW = $clog2(LATENCY + 1);

    // Cycles since reset, so that history checks skip the reset window.
    logic [CNTW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_cnt != CNTW'(LATENCY)) begin
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    // Every taken report shows up after the fixed latency.
    `GRDZ_ASSERT(a_lat_hit, (r_cnt == CNTW'(LATENCY)) && $past(start && !busy, LATENCY), o_valid)

    // No result appears without a report taken the latency before.
    `GRDZ_ASSERT_NEXT(a_lat_quiet, (r_cnt == CNTW'(LATENCY)) && !$past(start && !busy, LATENCY - 1), !o_valid)

    // Buttons come out exactly as they went in.
    `GRDZ_ASSERT(a_buttons, o_valid, o_buttons_out == $past(i_buttons_in, LATENCY))

    // A negative left x result needs a negative left x input.
    `GRDZ_ASSERT(a_sign, o_valid && o_left_x_out[15], $past(i_left_x_in[AXIS_BITS-1], LATENCY))

endmodule

bind gamepad_radial_deadzone_filter grdz_checker #(.AXIS_BITS(AXIS_BITS)) u_grdz_checker (.*);

`default_nettype wire

/* dv/tb_gamepad_radial_deadzone_filter.sv */
// ----------------------------------------------------------------------------
// tb_gamepad_radial_deadzone_filter
// Self-checking bench for the radial deadzone filter. A short table of
// directed reports runs first, then several configuration phases with random
// reports. Results are compared with typed rows or a behavioral predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_gamepad_radial_deadzone_filter;
    import grdz_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;   // no register lives at this index
    localparam int ITEMS_PER_PHASE = 200;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct packed {
        logic [15:0]        buttons;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [7:0]         lt;
        logic [7:0]         rt;
    } t_report;

    typedef struct packed {
        logic [15:0]        buttons;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [14:0]        lt;
        logic [14:0]        rt;
    } t_filtered;

    typedef struct {
        t_report   rpt;
        bit        pinned;
        t_filtered res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [CFGW-1:0] i_cfg_data;
    logic o_valid;
    t_report drv;
    t_filtered dut_res;

    // Expectation typed in by the directed table, travels with the report.
    logic pin_exp;
    t_filtered pin_res;

    // Shadow copy of the configuration registers.
    logic [14:0] sh_lim, sh_lim_y, sh_ldz, sh_rdz, sh_rdiv;
    logic [7:0]  sh_tdz, sh_tfull;

    t_filtered expected_q[$];
    int errors;
    int reports_sent;
    int words_checked;
    int idle_cycles;
    bit gaps_on;

    gamepad_radial_deadzone_filter uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_buttons_in       (drv.buttons),
        .i_left_x_in        (drv.lx),
        .i_left_y_in        (drv.ly),
        .i_right_x_in       (drv.rx),
        .i_right_y_in       (drv.ry),
        .i_left_trigger_in  (drv.lt),
        .i_right_trigger_in (drv.rt),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_buttons_out      (dut_res.buttons),
        .o_left_x_out       (dut_res.lx),
        .o_left_y_out       (dut_res.ly),
        .o_right_x_out      (dut_res.rx),
        .o_right_y_out      (dut_res.ry),
        .o_left_trigger_out (dut_res.lt),
        .o_right_trigger_out(dut_res.rt)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Integer square root, one bit at a time from the top.
    function automatic longint unsigned stick_radius(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    // Scale one axis by the ramp fraction num/den and its divisor, saturating.
    function automatic logic signed [15:0] scale_axis(input logic signed [15:0] axis,
            input longint unsigned num, input longint unsigned den,
            input longint unsigned div);
        longint unsigned mag;
        longint unsigned q;
        if (div == 0 || den == 0) return 16'sd0;
        mag = (axis < 0) ? longint'(-longint'(axis)) : longint'(axis);
        q = (num * mag * 32768) / (den * div);
        if (axis < 0) return (q >= 32768) ? -16'sd32768 : 16'(-longint'(q));
        return (q > 32767) ? 16'sd32767 : 16'(q);
    endfunction

    // Radial deadzone for one stick; both axes share the ramp.
    function automatic void filter_stick(input logic signed [15:0] x,
            input logic signed [15:0] y, input longint unsigned dz,
            input longint unsigned divx, input longint unsigned divy,
            output logic signed [15:0] ox, output logic signed [15:0] oy);
        longint unsigned lim;
        longint unsigned m;
        lim = sh_lim;
        ox = 0;
        oy = 0;
        if (dz >= lim) return;
        m = stick_radius(longint'(x) * longint'(x) + longint'(y) * longint'(y));
        if (m <= dz) return;
        if (m > lim) m = lim;
        ox = scale_axis(x, m - dz, lim - dz, divx);
        oy = scale_axis(y, m - dz, lim - dz, divy);
    endfunction

    function automatic logic [14:0] scale_trigger(input logic [7:0] t);
        longint unsigned q;
        if (sh_tfull <= sh_tdz || t <= sh_tdz) return 15'd0;
        q = (longint'(t - sh_tdz) * 32768) / longint'(sh_tfull - sh_tdz);
        return (q > 32767) ? 15'd32767 : 15'(q);
    endfunction

    function automatic t_filtered filter_report(input t_report r);
        t_filtered f;
        f.buttons = r.buttons;
        filter_stick(r.lx, r.ly, sh_ldz, sh_lim, sh_lim_y, f.lx, f.ly);
        filter_stick(r.rx, r.ry, sh_rdz, sh_rdiv, sh_rdiv, f.rx, f.ry);
        f.lt = scale_trigger(r.lt);
        f.rt = scale_trigger(r.rt);
        return f;
    endfunction

    // Monitor: checks result words, records accepted reports and writes.
    always @(posedge i_clk) begin
        bit progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                progress = 1'b1;
                words_checked <= words_checked + 1;
                if (expected_q.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: result word with none expected, actual %p", $time,
                             dut_res);
                end else if (dut_res !== expected_q[0]) begin
                    errors <= errors + 1;
                    $display("%0t: result mismatch, expected %p, actual %p", $time,
                             expected_q[0], dut_res);
                    void'(expected_q.pop_front());
                end else begin
                    void'(expected_q.pop_front());
                end
            end
            if (start && !busy) begin
                progress = 1'b1;
                expected_q.push_back(pin_exp ? pin_res : filter_report(drv));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                progress = 1'b1;
                case (i_cfg_index)
                    REG_STICK_LIMIT:   sh_lim   <= i_cfg_data;
                    REG_STICK_LIMIT_Y: sh_lim_y <= i_cfg_data;
                    REG_LEFT_DZ:       sh_ldz   <= i_cfg_data;
                    REG_RIGHT_DZ:      sh_rdz   <= i_cfg_data;
                    REG_RIGHT_DIV:     sh_rdiv  <= i_cfg_data;
                    REG_TRIG_DZ:       sh_tdz   <= i_cfg_data[7:0];
                    REG_TRIG_FULL:     sh_tfull <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            idle_cycles <= progress ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("tb_gamepad_radial_deadzone_filter failed");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = 0;
        if (gaps_on) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: n = 0;
                5, 6, 7, 8:    n = $urandom_range(1, 3);
                default:       n = $urandom_range(10, 60);
            endcase
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one report and hold it until it is taken.
    task automatic send_report(input t_report r, input bit pinned, input t_filtered res);
        drv <= r;
        pin_exp <= pinned;
        pin_res <= res;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        reports_sent++;
        idle_gap();
    endtask

    // Writes may follow back to back; the caller drops valid after the last.
    task automatic write_reg(input logic [2:0] idx, input logic [CFGW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Hold off until the pipeline has drained.
    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_axis(input int dz);
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 1) ? 32767 : -32768);
            1:       return 16'($urandom_range(0, 2 * dz + 2) - dz - 1);
            2:       return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_trigger();
        case ($urandom_range(0, 4))
            0:       return ($urandom_range(0, 1) ? 8'd255 : 8'd0);
            1:       return 8'(int'(sh_tdz) + $urandom_range(0, 2) - 1);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_report rand_report();
        t_report r;
        r.buttons = 16'($urandom);
        r.lx = rand_axis(sh_ldz);
        r.ly = rand_axis(sh_ldz);
        r.rx = rand_axis(sh_rdz);
        r.ry = rand_axis(sh_rdz);
        r.lt = rand_trigger();
        r.rt = rand_trigger();
        return r;
    endfunction

    initial begin
        t_dir_row rows[$];
        logic [CFGW-1:0] phase_cfg[7];
        t_filtered none;
        errors = 0;
        reports_sent = 0;
        words_checked = 0;
        idle_cycles = 0;
        gaps_on = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        drv = '0;
        pin_exp = 1'b0;
        pin_res = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_STICK_LIMIT;
        i_cfg_data = '0;
        none = '0;
        sh_lim = 15'd32767;
        sh_lim_y = 15'd32767;
        sh_ldz = 15'd7849;
        sh_rdz = 15'd8689;
        sh_rdiv = 15'd32767;
        sh_tdz = 8'd30;
        sh_tfull = 8'd255;

        // Directed reports under the reset configuration.
        rows.push_back('{'{16'h0000, 0, 0, 0, 0, 8'd0, 8'd0}, 1, '0});
        rows.push_back('{'{16'hFFFF, 0, 0, 0, 0, 8'd30, 8'd30},
                         1, '{16'hFFFF, 0, 0, 0, 0, 15'd0, 15'd0}});
        rows.push_back('{'{16'hA5A5, 16'sd32767, 0, 0, 16'sd32767, 8'd255, 8'd255},
                         1, '{16'hA5A5, 16'sd32767, 0, 0, 16'sd32767, 15'd32767,
                              15'd32767}});
        rows.push_back('{'{16'h5A5A, -16'sd32768, 0, 0, -16'sd32768, 8'd255, 8'd0},
                         1, '{16'h5A5A, -16'sd32768, 0, 0, -16'sd32768, 15'd32767,
                              15'd0}});
        rows.push_back('{'{16'h0001, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                           8'd0, 8'd255},
                         1, '{16'h0001, -16'sd32768, -16'sd32768, -16'sd32768,
                              -16'sd32768, 15'd0, 15'd32767}});
        // Just inside and just past each deadzone edge.
        rows.push_back('{'{16'h8000, 16'sd7849, 0, 0, 16'sd8689, 8'd30, 8'd29}, 1,
                         '{16'h8000, 0, 0, 0, 0, 15'd0, 15'd0}});
        rows.push_back('{'{16'h0002, 16'sd7850, 0, 0, -16'sd8690, 8'd31, 8'd128}, 0, none});
        rows.push_back('{'{16'h0004, 0, -16'sd7850, 16'sd8690, 0, 8'd254, 8'd1}, 0, none});
        rows.push_back('{'{16'h0008, 16'sd23170, 16'sd23170, -16'sd23170, 16'sd23170,
                           8'd100, 8'd200}, 0, none});
        rows.push_back('{'{16'h0010, 16'sd12000, -16'sd9000, 16'sd20000, -16'sd3000,
                           8'd60, 8'd240}, 0, none});
        rows.push_back('{'{16'h0020, -16'sd1, 16'sd32767, 16'sd1, -16'sd32768,
                           8'd31, 8'd31}, 0, none});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_report(rows[i].rpt, rows[i].pinned, rows[i].res);
        // Let the sender wait until the pipeline is empty at least once.
        drain();

        // Each phase reloads all registers, then streams random reports.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: phase_cfg = '{15'd32767, 15'd32767, 15'd0, 15'd0, 15'd32767,
                                 15'd0, 15'd255};
                1: phase_cfg = '{15'd1, 15'd1, 15'd0, 15'd32766, 15'd1,
                                 15'd254, 15'd255};
                2: phase_cfg = '{15'd1000, 15'd500, 15'd200, 15'd100, 15'd0,
                                 15'd100, 15'd50};
                3: phase_cfg = '{15'd32767, 15'd0, 15'd32766, 15'd0, 15'd32767,
                                 15'h7F00, 15'h7F01};
                4: phase_cfg = '{15'd0, 15'd3, 15'd0, 15'd5, 15'd2, 15'd255, 15'd0};
                default: begin
                    foreach (phase_cfg[k]) phase_cfg[k] = 15'($urandom);
                    phase_cfg[REG_STICK_LIMIT] = 15'($urandom_range(1, 32767));
                end
            endcase
            if (ph == 1) write_reg(REG_NONE, 15'h7FFF);
            write_reg(REG_STICK_LIMIT,   phase_cfg[REG_STICK_LIMIT]);
            write_reg(REG_STICK_LIMIT_Y, phase_cfg[REG_STICK_LIMIT_Y]);
            write_reg(REG_LEFT_DZ,       phase_cfg[REG_LEFT_DZ]);
            write_reg(REG_RIGHT_DZ,      phase_cfg[REG_RIGHT_DZ]);
            write_reg(REG_RIGHT_DIV,     phase_cfg[REG_RIGHT_DIV]);
            write_reg(REG_TRIG_DZ,       phase_cfg[REG_TRIG_DZ]);
            write_reg(REG_TRIG_FULL,     phase_cfg[REG_TRIG_FULL]);
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
            gaps_on = (ph % 3 != 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_report(rand_report(), 0, none);
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d reports over 8 register settings, checked %0d result words.",
                 reports_sent, words_checked);
        $display("Covered deadzone edges, clamp, divisor zero and trigger saturation.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb_gamepad_radial_deadzone_filter passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors,
                     expected_q.size());
            $display("tb_gamepad_radial_deadzone_filter failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
